>>> sv/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int PTR_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int CNT_W       = 16;
    localparam int IDX_W       = 2;
    localparam int BTN_W       = 3;
    localparam int THR_W       = 2 * CNT_W + 1;

    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] HOLD_STEP = CNT_W'(3);

    localparam logic [CNT_W-1:0] SHORT_MS_RST  = CNT_W'(30);
    localparam logic [CNT_W-1:0] LONG_MS_RST   = CNT_W'(1000);
    localparam logic [CNT_W-1:0] REPEAT_MS_RST = CNT_W'(200);

    typedef enum logic [IDX_W-1:0] {
        REG_SHORT_MS  = 2'd0,
        REG_LONG_MS   = 2'd1,
        REG_REPEAT_MS = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [CNT_W-1:0] short_ms;
        logic [CNT_W-1:0] long_ms;
        logic [CNT_W-1:0] repeat_ms;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] hold_time;
        logic [CNT_W-1:0] repeat_count;
        logic             long_fired;
    } btn_state_t;

    typedef struct packed {
        logic short_press;
        logic long_press;
        logic repeat_press;
        logic long_latched;
    } events_t;

endpackage

`default_nettype wire

>>> sv/button_press_classifier.sv
// button press classifier: short press, long press and autorepeat for
// three push buttons, one button examined per 1 ms tick in round-robin order
//
// input channel: in_valid/in_ready with buttons_pressed, one request per tick
// result channel: out_valid/out_ready with button_index, short_press,
//   long_press, repeat_press and long_latched, exactly one result per request
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//   short_ms, 1 long_ms, 2 repeat_ms; other indexes are dropped; cfg_ready
//   is always high; write only while no request is outstanding
//
// latency is one cycle: a request taken at one edge shows its result at
// the next. one request per cycle is sustained; the per-button update
// (one 16x17 multiply for the repeat threshold, adds and compares) sits
// between the state registers and the result register
//
// reset clears the scan pointer, all per-button counters and the result
// register and loads the default thresholds (30, 1000, 200 ms)
// when the receiver stalls the result register holds and in_ready drops,
// so in_ready follows out_ready while a result is waiting
`default_nettype none

module button_press_classifier (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [bpc_pkg::BTN_W-1:0]    buttons_pressed,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [bpc_pkg::IDX_W-1:0]         button_index,
    output logic                              short_press,
    output logic                              long_press,
    output logic                              repeat_press,
    output logic                              long_latched,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [bpc_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [bpc_pkg::CNT_W-1:0]    cfg_data
);

    bpc_pkg::cfg_t       cfg;
    bpc_pkg::btn_state_t btn_reg [bpc_pkg::NUM_BUTTONS];
    bpc_pkg::btn_state_t cur;
    bpc_pkg::btn_state_t nxt;
    bpc_pkg::events_t    ev;
    bpc_pkg::events_t    ev_reg;

    logic [bpc_pkg::PTR_W-1:0] ptr_reg;
    logic [bpc_pkg::PTR_W-1:0] ptr_next;
    logic [bpc_pkg::IDX_W-1:0] index_reg;
    logic                      out_valid_reg;
    logic                      pressed;
    logic                      accept;

    bpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // pointer advances before use
    assign ptr_next = (ptr_reg == bpc_pkg::PTR_W'(bpc_pkg::NUM_BUTTONS - 1))
                      ? '0 : (ptr_reg + bpc_pkg::PTR_W'(1));
    assign cur      = btn_reg[ptr_next];
    assign pressed  = buttons_pressed[ptr_next];

    bpc_button_update u_update (
        .cfg     (cfg),
        .cur     (cur),
        .pressed (pressed),
        .nxt     (nxt),
        .ev      (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < bpc_pkg::NUM_BUTTONS; i++)
            begin
                btn_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                ptr_reg          <= ptr_next;
                btn_reg[ptr_next] <= nxt;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg    <= '0;
            index_reg <= '0;
        end
        else if (accept)
        begin
            ev_reg    <= ev;
            index_reg <= bpc_pkg::IDX_W'(ptr_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign button_index = index_reg;
    assign short_press  = ev_reg.short_press;
    assign long_press   = ev_reg.long_press;
    assign repeat_press = ev_reg.repeat_press;
    assign long_latched = ev_reg.long_latched;

endmodule

`default_nettype wire

>>> sv/bpc_cfg_regs.sv
`default_nettype none

module bpc_cfg_regs (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [bpc_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [bpc_pkg::CNT_W-1:0] cfg_data,
    output bpc_pkg::cfg_t               cfg
);

    bpc_pkg::cfg_t cfg_reg;
    bpc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                bpc_pkg::REG_SHORT_MS:  cfg_next.short_ms  = cfg_data;
                bpc_pkg::REG_LONG_MS:   cfg_next.long_ms   = cfg_data;
                bpc_pkg::REG_REPEAT_MS: cfg_next.repeat_ms = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_ms  <= bpc_pkg::SHORT_MS_RST;
            cfg_reg.long_ms   <= bpc_pkg::LONG_MS_RST;
            cfg_reg.repeat_ms <= bpc_pkg::REPEAT_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/bpc_button_update.sv
`default_nettype none

module bpc_button_update (
    input  wire bpc_pkg::cfg_t       cfg,
    input  wire bpc_pkg::btn_state_t cur,
    input  wire logic                pressed,
    output bpc_pkg::btn_state_t      nxt,
    output bpc_pkg::events_t         ev
);

    logic [bpc_pkg::CNT_W-1:0] hold_inc;
    logic [bpc_pkg::CNT_W:0]   count_p1;
    logic [bpc_pkg::THR_W-1:0] repeat_thr;
    logic                      repeat_hit;
    logic                      long_hit;
    logic                      short_hit;

    // saturating +3 ms
    assign hold_inc = (cur.hold_time > (bpc_pkg::CNT_MAX - bpc_pkg::HOLD_STEP))
                      ? bpc_pkg::CNT_MAX : (cur.hold_time + bpc_pkg::HOLD_STEP);

    assign count_p1   = {1'b0, cur.repeat_count} + (bpc_pkg::CNT_W+1)'(1);
    assign repeat_thr = bpc_pkg::THR_W'(cfg.repeat_ms * count_p1);
    assign repeat_hit = {(bpc_pkg::THR_W-bpc_pkg::CNT_W)'(0), hold_inc} > repeat_thr;
    assign long_hit   = (hold_inc > cfg.long_ms) && !cur.long_fired;
    assign short_hit  = (cur.hold_time > cfg.short_ms) && (cur.hold_time < cfg.long_ms);

    always_comb
    begin
        nxt = '0;
        ev  = '0;
        if (pressed)
        begin
            nxt.hold_time    = hold_inc;
            nxt.repeat_count = cur.repeat_count;
            nxt.long_fired   = cur.long_fired | long_hit;
            if (repeat_hit && (cur.repeat_count != bpc_pkg::CNT_MAX))
            begin
                nxt.repeat_count = cur.repeat_count + bpc_pkg::CNT_W'(1);
            end
            ev.repeat_press = repeat_hit;
            ev.long_press   = long_hit;
            ev.long_latched = cur.long_fired | long_hit;
        end
        else
        begin
            // release clears the counters
            ev.short_press = short_hit;
        end
    end

endmodule

`default_nettype wire
